/* rtl/cga_pkg.sv */
`default_nettype none

package cga_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_FONT_BASE    = 3'd0;
   localparam logic [2:0] REG_TABLE_OFFSET = 3'd1;
   localparam logic [2:0] REG_WIDTH        = 3'd2;
   localparam logic [2:0] REG_HEIGHT       = 3'd3;
   localparam logic [2:0] REG_BPP          = 3'd4;

   // register reset values
   localparam logic [31:0] RST_FONT_BASE    = 32'h0000_0000;
   localparam logic [31:0] RST_TABLE_OFFSET = 32'h0000_0000;
   localparam logic [7:0]  RST_WIDTH        = 8'd8;
   localparam logic [7:0]  RST_HEIGHT       = 8'd8;
   localparam logic [3:0]  RST_BPP          = 4'd1;
   // stride for the reset geometry: one byte per row, one bit per pixel, eight rows
   localparam logic [16:0] RST_STRIDE       = 17'd8;

   // private codes and their redirect targets
   localparam logic [15:0] CODE_PRIV_A   = 16'hF056;
   localparam logic [15:0] CODE_PRIV_B   = 16'hF040;
   localparam logic [15:0] CODE_REDIR_A  = 16'h81FA;
   localparam logic [15:0] CODE_REDIR_B  = 16'h81F9;

   // single byte codes
   localparam logic [15:0] BYTE_MAX      = 16'h00FF;
   localparam logic [15:0] BYTE_BIAS     = 16'h01E0;

   // symbol and kana ranges
   localparam logic [15:0] SYM_LO        = 16'h8140;
   localparam logic [15:0] SYM_HI        = 16'h81FF;
   localparam logic [15:0] SYM_BIAS      = 16'h8140;
   localparam logic [15:0] KATA_LO       = 16'h839F;
   localparam logic [15:0] KATA_HI       = 16'h83D6;
   localparam logic [15:0] KATA_BIAS     = 16'h81C0;
   localparam logic [15:0] CYR_LO        = 16'h8440;
   localparam logic [15:0] CYR_HI        = 16'h8491;
   localparam logic [15:0] CYR_BIAS      = 16'h8200;
   localparam logic [15:0] EXT_LO        = 16'h8740;
   localparam logic [15:0] EXT_HI        = 16'h879C;
   localparam logic [15:0] EXT_BIAS      = 16'h82C0;

   // kana block with gaps
   localparam logic [15:0] KANA_LO       = 16'h8240;
   localparam logic [15:0] KANA_HI       = 16'h84BF;
   localparam logic [15:0] HIRA_A_HI     = 16'h829A;
   localparam logic [15:0] HIRA_B_LO     = 16'h829F;
   localparam logic [15:0] HIRA_B_HI     = 16'h82F1;
   localparam logic [15:0] HIRA_BIAS     = 16'h8180;
   localparam logic [15:0] KROW_LO       = 16'h8340;
   localparam logic [15:0] KROW_HI       = 16'h83FF;
   localparam logic [12:0] GAP_SLOT      = 13'd0;

   // kanji blocks
   localparam logic [15:0] KANJI_A_LO    = 16'h8840;
   localparam logic [15:0] KANJI_A_HI    = 16'h988F;
   localparam logic [7:0]  KANJI_A_ROW   = 8'h88;
   localparam logic [12:0] KANJI_A_BIAS  = 13'h0500;
   localparam logic [15:0] KANJI_B_LO    = 16'h9890;
   localparam logic [15:0] KANJI_B_HI    = 16'h9FFF;
   localparam logic [7:0]  KANJI_B_ROW   = 8'h98;
   localparam logic [12:0] KANJI_B_BIAS  = 13'h1100;
   localparam logic [15:0] KANJI_C_LO    = 16'hE040;
   localparam logic [15:0] KANJI_C_HI    = 16'hEAAF;
   localparam logic [7:0]  KANJI_C_ROW   = 8'hE0;
   localparam logic [12:0] KANJI_C_BIAS  = 13'h1700;
   localparam logic [12:0] SLOTS_PER_ROW = 13'd192;

   // fallback glyph is the slot of code 0x81A1
   localparam logic [12:0] FALLBACK_SLOT = 13'h0061;
   // highest slot any range can produce
   localparam logic [12:0] MAX_SLOT      = 13'd7983;

   // derived geometry handed to the address stages
   typedef struct packed {
      logic [31:0] base_sum;
      logic [16:0] stride;
   } cfg_type;

   // mapped slot leaving the first stage
   typedef struct packed {
      logic        valid;
      logic [12:0] slot;
      logic        unsupported;
   } slot_stage_type;

   // finished result
   typedef struct packed {
      logic        valid;
      logic [12:0] slot;
      logic        unsupported;
      logic [31:0] address;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/cga_csr.sv */
`default_nettype none

module cga_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data,
   output cga_pkg::cfg_type      cfg
);

   logic [31:0] base_ff,   base_in;
   logic [31:0] offset_ff, offset_in;
   logic [7:0]  width_ff,  width_in;
   logic [7:0]  height_ff, height_in;
   logic [3:0]  bpp_ff,    bpp_in;
   logic [16:0] stride_ff;
   logic [31:0] base_sum_ff;

   logic [8:0]  width_round;
   logic [9:0]  row_bytes;
   logic [17:0] stride_full;
   logic [16:0] stride_in;
   logic [31:0] base_sum_in;

   // register writes
   always_comb begin
      base_in   = base_ff;
      offset_in = offset_ff;
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cga_pkg::REG_FONT_BASE:    base_in   = csr_data;
            cga_pkg::REG_TABLE_OFFSET: offset_in = csr_data;
            cga_pkg::REG_WIDTH:        width_in  = csr_data[7:0];
            cga_pkg::REG_HEIGHT:       height_in = csr_data[7:0];
            cga_pkg::REG_BPP:          bpp_in    = csr_data[3:0];
            default: ;
         endcase
      end
   end

   // bytes per row times bpp times rows, and base plus table offset
   always_comb begin
      width_round = {1'b0, width_ff} + 9'd7;
      row_bytes   = 10'(width_round[8:3]) * 10'(bpp_ff);
      stride_full = 18'(row_bytes) * 18'(height_ff);
      stride_in   = stride_full[16:0];
      base_sum_in = base_ff + offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= cga_pkg::RST_FONT_BASE;
         offset_ff   <= cga_pkg::RST_TABLE_OFFSET;
         width_ff    <= cga_pkg::RST_WIDTH;
         height_ff   <= cga_pkg::RST_HEIGHT;
         bpp_ff      <= cga_pkg::RST_BPP;
         stride_ff   <= cga_pkg::RST_STRIDE;
         base_sum_ff <= cga_pkg::RST_FONT_BASE + cga_pkg::RST_TABLE_OFFSET;
      end else begin
         base_ff     <= base_in;
         offset_ff   <= offset_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         bpp_ff      <= bpp_in;
         stride_ff   <= stride_in;
         base_sum_ff <= base_sum_in;
      end
   end

   assign cfg.base_sum = base_sum_ff;
   assign cfg.stride   = stride_ff;

endmodule

`default_nettype wire

/* rtl/cga_slot_map.sv */
`default_nettype none

module cga_slot_map (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [15:0]         char_code,
   output cga_pkg::slot_stage_type  stage
);

   logic [15:0] code;
   logic [7:0]  hi;
   logic [7:0]  lo;
   logic [15:0] byte_slot;
   logic [15:0] sym_slot;
   logic [15:0] kata_slot;
   logic [15:0] cyr_slot;
   logic [15:0] ext_slot;
   logic [15:0] hira_slot;
   logic [7:0]  row_a;
   logic [7:0]  row_b;
   logic [7:0]  row_c;
   logic [12:0] kanji_a_slot;
   logic [12:0] kanji_b_slot;
   logic [12:0] kanji_c_slot;
   logic [12:0] slot_in;
   logic        unsupported_in;

   logic        valid_ff;
   logic [12:0] slot_ff;
   logic        unsupported_ff;

   // redirect the two private codes
   always_comb begin
      if (char_code == cga_pkg::CODE_PRIV_A) begin
         code = cga_pkg::CODE_REDIR_A;
      end else if (char_code == cga_pkg::CODE_PRIV_B) begin
         code = cga_pkg::CODE_REDIR_B;
      end else begin
         code = char_code;
      end
   end

   // candidate slots for every range
   always_comb begin
      hi           = code[15:8];
      lo           = code[7:0];
      byte_slot    = code + cga_pkg::BYTE_BIAS;
      sym_slot     = code - cga_pkg::SYM_BIAS;
      kata_slot    = code - cga_pkg::KATA_BIAS;
      cyr_slot     = code - cga_pkg::CYR_BIAS;
      ext_slot     = code - cga_pkg::EXT_BIAS;
      hira_slot    = code - cga_pkg::HIRA_BIAS;
      row_a        = hi - cga_pkg::KANJI_A_ROW;
      row_b        = hi - cga_pkg::KANJI_B_ROW;
      row_c        = hi - cga_pkg::KANJI_C_ROW;
      kanji_a_slot = 13'(13'(row_a[4:0]) * cga_pkg::SLOTS_PER_ROW) + 13'(lo)
                     + cga_pkg::KANJI_A_BIAS;
      kanji_b_slot = 13'(13'(row_b[4:0]) * cga_pkg::SLOTS_PER_ROW) + 13'(lo)
                     + cga_pkg::KANJI_B_BIAS;
      kanji_c_slot = 13'(13'(row_c[4:0]) * cga_pkg::SLOTS_PER_ROW) + 13'(lo)
                     + cga_pkg::KANJI_C_BIAS;
   end

   // priority chain, first match wins
   always_comb begin
      unsupported_in = 1'b0;
      if (code <= cga_pkg::BYTE_MAX) begin
         slot_in = byte_slot[12:0];
      end else if (code >= cga_pkg::SYM_LO && code <= cga_pkg::SYM_HI) begin
         slot_in = sym_slot[12:0];
      end else if (code >= cga_pkg::KATA_LO && code <= cga_pkg::KATA_HI) begin
         slot_in = kata_slot[12:0];
      end else if (code >= cga_pkg::CYR_LO && code <= cga_pkg::CYR_HI) begin
         slot_in = cyr_slot[12:0];
      end else if (code >= cga_pkg::EXT_LO && code <= cga_pkg::EXT_HI) begin
         slot_in = ext_slot[12:0];
      end else if (code >= cga_pkg::KANA_LO && code <= cga_pkg::KANA_HI) begin
         // hiragana pieces, the katakana row, gaps read as slot zero
         if (code <= cga_pkg::HIRA_A_HI ||
             (code >= cga_pkg::HIRA_B_LO && code <= cga_pkg::HIRA_B_HI)) begin
            slot_in = hira_slot[12:0];
         end else if (code >= cga_pkg::KROW_LO && code <= cga_pkg::KROW_HI) begin
            slot_in = kata_slot[12:0];
         end else begin
            slot_in = cga_pkg::GAP_SLOT;
         end
      end else if (code >= cga_pkg::KANJI_A_LO && code <= cga_pkg::KANJI_A_HI) begin
         slot_in = kanji_a_slot;
      end else if (code >= cga_pkg::KANJI_B_LO && code <= cga_pkg::KANJI_B_HI) begin
         slot_in = kanji_b_slot;
      end else if (code >= cga_pkg::KANJI_C_LO && code <= cga_pkg::KANJI_C_HI) begin
         slot_in = kanji_c_slot;
      end else begin
         slot_in        = cga_pkg::FALLBACK_SLOT;
         unsupported_in = 1'b1;
      end
   end

   // stage one valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      unsupported_ff <= unsupported_in;
   end

   assign stage.valid       = valid_ff;
   assign stage.slot        = slot_ff;
   assign stage.unsupported = unsupported_ff;

endmodule

`default_nettype wire

/* rtl/cga_addr_calc.sv */
`default_nettype none

module cga_addr_calc (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cga_pkg::slot_stage_type stage,
   input  wire cga_pkg::cfg_type        cfg,
   output cga_pkg::rsp_type             rsp
);

   logic        mul_valid_ff;
   logic [12:0] mul_slot_ff;
   logic        mul_unsupported_ff;
   logic [29:0] product_ff;
   logic [29:0] product_in;

   logic        out_valid_ff;
   logic [12:0] out_slot_ff;
   logic        out_unsupported_ff;
   logic [31:0] address_ff;
   logic [31:0] address_in;

   // slot times stride, then add base plus offset
   assign product_in = 30'(stage.slot) * 30'(cfg.stride);
   assign address_in = cfg.base_sum + 32'(product_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= stage.valid;
         out_valid_ff <= mul_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mul_slot_ff        <= stage.slot;
      mul_unsupported_ff <= stage.unsupported;
      product_ff         <= product_in;
      out_slot_ff        <= mul_slot_ff;
      out_unsupported_ff <= mul_unsupported_ff;
      address_ff         <= address_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.slot        = out_slot_ff;
   assign rsp.unsupported = out_unsupported_ff;
   assign rsp.address     = address_ff;

endmodule

`default_nettype wire

/* rtl/char_code_to_glyph_address.sv */
// channel   | ports                                    | handshake
// ----------+------------------------------------------+---------------------------------
// request   | start, busy, req_char_code               | taken when start and not busy
// result    | rsp_valid, rsp_glyph_slot,               | one-cycle strobe, cannot stall
//           | rsp_unsupported, rsp_glyph_address       |
// csr       | csr_wr_en, csr_index, csr_data           | written when csr_wr_en is high
//
// one request per cycle; busy is never raised
// the result strobe follows the request through the slot decode, the slot times
// stride multiply and then the base add, one register stage each
// the csr block registers a written field, then registers the stride and base sum derived from it
// reset clears the pipeline valid bits and loads the register reset values
// the receiver cannot stall, so nothing is held back inside the pipeline

`default_nettype none

module char_code_to_glyph_address (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_char_code,
   output logic             rsp_valid,
   output logic [12:0]      rsp_glyph_slot,
   output logic             rsp_unsupported,
   output logic [31:0]      rsp_glyph_address,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cga_pkg::cfg_type        cfg;
   cga_pkg::slot_stage_type stage;
   cga_pkg::rsp_type        rsp;
   logic                    req_accept;

   // the pipeline takes a request every cycle
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // configuration registers and derived geometry
   cga_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // code to slot
   cga_slot_map u_slot_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .char_code (req_char_code),
      .stage     (stage)
   );

   // slot to address
   cga_addr_calc u_addr_calc (
      .clock (clock),
      .reset (reset),
      .stage (stage),
      .cfg   (cfg),
      .rsp   (rsp)
   );

   assign rsp_valid         = rsp.valid;
   assign rsp_glyph_slot    = rsp.slot;
   assign rsp_unsupported   = rsp.unsupported;
   assign rsp_glyph_address = rsp.address;

   // every result comes from an earlier request taken at the pipeline input
   a_rsp_from_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 3))
      else $error("result without a request three cycles earlier");

   // every request taken yields a result unless reset hits the pipeline meanwhile
   a_req_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##3 (rsp_valid || $past(reset, 1) || $past(reset, 2)))
      else $error("request lost in the pipeline");

   // fallback results carry the fallback slot
   a_fallback_slot : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unsupported) |-> (rsp_glyph_slot == cga_pkg::FALLBACK_SLOT))
      else $error("unsupported flag without the fallback slot");

   // no range maps above the last kanji slot
   a_slot_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_glyph_slot <= cga_pkg::MAX_SLOT))
      else $error("glyph slot out of range");

endmodule

`default_nettype wire

/* tb/sv/glyph_address_checker.sv */
`timescale 1ns / 1ps

module glyph_address_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_char_code,
   input  logic        rsp_valid,
   input  logic [12:0] rsp_glyph_slot,
   input  logic        rsp_unsupported,
   input  logic [31:0] rsp_glyph_address,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          pending
);

   localparam logic [15:0] PRIVATE_CODE_A  = 16'hF056;
   localparam logic [15:0] PRIVATE_CODE_B  = 16'hF040;
   localparam logic [15:0] TARGET_CODE_A   = 16'h81FA;
   localparam logic [15:0] TARGET_CODE_B   = 16'h81F9;
   localparam logic [15:0] FALLBACK_CODE   = 16'h81A1;
   localparam int unsigned ROW_SLOTS       = 192;
   localparam int          REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [15:0] code;
      logic [12:0] slot;
      logic        unsupported;
      logic [31:0] address;
   } glyph_result_type;

   // shadow copy of the font geometry registers
   logic [31:0] font_base;
   logic [31:0] table_offset;
   logic [7:0]  width_px;
   logic [7:0]  height_px;
   logic [3:0]  pixel_bits;

   glyph_result_type expected_glyphs[$];

   // range chain, first match wins; returns 0 when no range holds the code
   function automatic logic slot_of_code(input logic [15:0] c, output logic [12:0] slot);
      int unsigned code;
      int unsigned hi;
      int unsigned lo;
      int unsigned s;
      logic        hit;
      code = 32'(c);
      hi   = 32'(c[15:8]);
      lo   = 32'(c[7:0]);
      s    = 0;
      hit  = 1'b1;
      if (code <= 'h00FF)
         s = code + 'h1E0;
      else if (code >= 'h8140 && code <= 'h81FF)
         s = code - 'h8140;
      else if (code >= 'h839F && code <= 'h83D6)
         s = code - 'h81C0;
      else if (code >= 'h8440 && code <= 'h8491)
         s = code - 'h8200;
      else if (code >= 'h8740 && code <= 'h879C)
         s = code - 'h82C0;
      else if (code >= 'h8240 && code <= 'h84BF) begin
         // hiragana runs, katakana row, everything else in the block is a gap
         if (code <= 'h829A || (code >= 'h829F && code <= 'h82F1))
            s = code - 'h8180;
         else if (code >= 'h8340 && code <= 'h83FF)
            s = code - 'h81C0;
         else
            s = 0;
      end else if (code >= 'h8840 && code <= 'h988F)
         s = (hi - 'h88) * ROW_SLOTS + lo + 'h500;
      else if (code >= 'h9890 && code <= 'h9FFF)
         s = (hi - 'h98) * ROW_SLOTS + lo + 'h1100;
      else if (code >= 'hE040 && code <= 'hEAAF)
         s = (hi - 'hE0) * ROW_SLOTS + lo + 'h1700;
      else
         hit = 1'b0;
      slot = s[12:0];
      return hit;
   endfunction

   function automatic glyph_result_type predict_glyph(input logic [15:0] char_code);
      glyph_result_type r;
      logic [15:0]      c;
      logic [12:0]      s;
      logic [63:0]      w64;
      logic [63:0]      stride;
      logic [63:0]      addr;
      r.code = char_code;
      c = char_code;
      // private codes redirect before the range lookup
      if (c == PRIVATE_CODE_A)
         c = TARGET_CODE_A;
      else if (c == PRIVATE_CODE_B)
         c = TARGET_CODE_B;
      r.unsupported = 1'b0;
      if (!slot_of_code(c, s)) begin
         void'(slot_of_code(FALLBACK_CODE, s));
         r.unsupported = 1'b1;
      end
      r.slot = s;
      // bytes per row times bits per pixel times rows, all wide to avoid overflow
      w64    = 64'(width_px);
      stride = ((w64 + 64'd7) >> 3) * 64'(pixel_bits) * 64'(height_px);
      addr   = 64'(font_base) + 64'(table_offset) + 64'(s) * stride;
      r.address = addr[31:0];
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      glyph_result_type want;
      if (reset) begin
         font_base    = 32'h0;
         table_offset = 32'h0;
         width_px     = 8'd8;
         height_px    = 8'd8;
         pixel_bits   = 4'd1;
         expected_glyphs.delete();
         mismatches   = 0;
      end else begin
         // register writes; indexes past the list are ignored
         if (csr_wr_en) begin
            case (csr_index)
               cga_pkg::REG_FONT_BASE:    font_base    = csr_data;
               cga_pkg::REG_TABLE_OFFSET: table_offset = csr_data;
               cga_pkg::REG_WIDTH:        width_px     = csr_data[7:0];
               cga_pkg::REG_HEIGHT:       height_px    = csr_data[7:0];
               cga_pkg::REG_BPP:          pixel_bits   = csr_data[3:0];
               default: ;
            endcase
         end

         // result against the oldest outstanding request
         if (rsp_valid) begin
            if (expected_glyphs.size() == 0) begin
               note_mismatch($sformatf("unexpected result: slot %0d unsupported %0b address %h",
                  rsp_glyph_slot, rsp_unsupported, rsp_glyph_address));
            end else begin
               want = expected_glyphs.pop_front();
               if (rsp_glyph_slot !== want.slot || rsp_unsupported !== want.unsupported ||
                   rsp_glyph_address !== want.address)
                  note_mismatch($sformatf(
                     "code %h: expected slot %0d unsupported %0b address %h, got %0d %0b %h",
                     want.code, want.slot, want.unsupported, want.address,
                     rsp_glyph_slot, rsp_unsupported, rsp_glyph_address));
            end
         end

         // accepted request
         if (start && !busy)
            expected_glyphs.push_back(predict_glyph(req_char_code));
      end
      pending = expected_glyphs.size();
   end

endmodule

/* tb/sv/char_code_to_glyph_address_test.sv */
`timescale 1ns / 1ps

module char_code_to_glyph_address_test;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          PHASE_ITEMS   = 150;
   localparam int          PHASE_COUNT   = 8;
   localparam int          DIRECTED_LEN  = 26;
   localparam int          EDGE_COUNT    = 25;
   localparam logic [2:0]  REG_SPARE_LO  = 3'd5;
   localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        start         = 1'b0;
   logic [15:0] req_char_code = 16'h0;
   logic        csr_wr_en     = 1'b0;
   logic [2:0]  csr_index     = 3'd0;
   logic [31:0] csr_data      = 32'h0;

   logic        busy;
   logic        rsp_valid;
   logic [12:0] rsp_glyph_slot;
   logic        rsp_unsupported;
   logic [31:0] rsp_glyph_address;

   int          mismatches;
   int          pending;
   int          cycles   = 0;
   int          idle_pct = 0;

   logic [15:0] directed_codes [0:DIRECTED_LEN-1];

   char_code_to_glyph_address dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_glyph_slot    (rsp_glyph_slot),
      .rsp_unsupported   (rsp_unsupported),
      .rsp_glyph_address (rsp_glyph_address),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   glyph_address_checker glyph_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_glyph_slot    (rsp_glyph_slot),
      .rsp_unsupported   (rsp_unsupported),
      .rsp_glyph_address (rsp_glyph_address),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("char_code_to_glyph_address_test: done, errors");
         $finish;
      end
   end

   // range boundaries and private codes for near-edge stimulus
   function automatic logic [15:0] range_edge(input int i);
      case (i)
         0:  return 16'h0000;
         1:  return 16'h00FF;
         2:  return 16'h8140;
         3:  return 16'h81FF;
         4:  return 16'h839F;
         5:  return 16'h83D6;
         6:  return 16'h8440;
         7:  return 16'h8491;
         8:  return 16'h8740;
         9:  return 16'h879C;
         10: return 16'h8240;
         11: return 16'h829A;
         12: return 16'h829F;
         13: return 16'h82F1;
         14: return 16'h8340;
         15: return 16'h83FF;
         16: return 16'h84BF;
         17: return 16'h8840;
         18: return 16'h988F;
         19: return 16'h9890;
         20: return 16'h9FFF;
         21: return 16'hE040;
         22: return 16'hEAAF;
         23: return 16'hF056;
         default: return 16'hF040;
      endcase
   endfunction

   // half mapped ranges, a quarter near boundaries, the rest anywhere in 16 bits
   function automatic logic [15:0] pick_code();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         case ($urandom_range(0, 9))
            0: return 16'($urandom_range(16'h0000, 16'h00FF));
            1: return 16'($urandom_range(16'h8140, 16'h81FF));
            2: return 16'($urandom_range(16'h839F, 16'h83D6));
            3: return 16'($urandom_range(16'h8440, 16'h8491));
            4: return 16'($urandom_range(16'h8740, 16'h879C));
            5: return 16'($urandom_range(16'h8240, 16'h84BF));
            6: return 16'($urandom_range(16'h8840, 16'h988F));
            7: return 16'($urandom_range(16'h9890, 16'h9FFF));
            8: return 16'($urandom_range(16'hE040, 16'hEAAF));
            default: return $urandom_range(0, 1) ? 16'hF056 : 16'hF040;
         endcase
      end else if (sel < 75) begin
         return 16'(range_edge($urandom_range(0, EDGE_COUNT - 1))
                    + $urandom_range(0, 2) - 1);
      end
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // one request; an optional gap with start low first
   task automatic send_code(input logic [15:0] code);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start         <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop issuing and wait for every outstanding result
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // back-to-back register writes, junk in the unused upper bits of narrow ones
   task automatic apply_config(input logic [31:0] base, input logic [31:0] offset,
                               input logic [7:0] width, input logic [7:0] height,
                               input logic [3:0] bpp);
      logic [31:0] junk;
      csr_wr_en <= 1'b1;
      csr_index <= cga_pkg::REG_FONT_BASE;
      csr_data  <= base;
      @(posedge clock);
      csr_index <= cga_pkg::REG_TABLE_OFFSET;
      csr_data  <= offset;
      @(posedge clock);
      junk = $urandom();
      csr_index <= cga_pkg::REG_WIDTH;
      csr_data  <= {junk[31:8], width};
      @(posedge clock);
      junk = $urandom();
      csr_index <= cga_pkg::REG_HEIGHT;
      csr_data  <= {junk[31:8], height};
      @(posedge clock);
      junk = $urandom();
      csr_index <= cga_pkg::REG_BPP;
      csr_data  <= {junk[31:4], bpp};
      @(posedge clock);
      // an index past the list must leave everything alone
      csr_index <= 3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
      csr_data  <= $urandom();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // wait for the stride and base sum to settle after the last write
      repeat (3) @(posedge clock);
   endtask

   initial begin
      logic [31:0] base;
      logic [31:0] offset;
      logic [7:0]  width;
      logic [7:0]  height;
      logic [3:0]  bpp;

      directed_codes = '{16'h0000, 16'h00FF, 16'h0100, 16'h8140, 16'h81A1, 16'h81FF,
                         16'h839F, 16'h83D6, 16'h8440, 16'h8491, 16'h8740, 16'h879C,
                         16'h8240, 16'h829A, 16'h829B, 16'h829F, 16'h82F1, 16'h8340,
                         16'h84BF, 16'h8840, 16'h988F, 16'h9890, 16'h9FFF, 16'hEAAF,
                         16'hF056, 16'hF040};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed codes on the reset geometry, back to back
      for (int i = 0; i < DIRECTED_LEN; i++)
         send_code(directed_codes[i]);
      send_code(16'hFFFF);
      drain();

      // random phases, each under its own geometry and idle rate
      for (int p = 0; p < PHASE_COUNT; p++) begin
         base   = $urandom();
         offset = $urandom();
         width  = 8'($urandom_range(0, 255));
         height = 8'($urandom_range(0, 255));
         bpp    = 4'($urandom_range(0, 15));
         case (p)
            0: begin
               base   = 32'hFFFF_FFFF;
               offset = 32'hFFFF_FFFF;
               width  = 8'hFF;
               height = 8'hFF;
               bpp    = 4'hF;
               idle_pct = 0;
            end
            1: begin
               width    = 8'h00;
               idle_pct = 61;
            end
            2: begin
               bpp      = 4'h0;
               idle_pct = 0;
            end
            3: begin
               height   = 8'h00;
               idle_pct = 24;
            end
            4: begin
               base     = 32'h0;
               offset   = 32'h0;
               width    = 8'd1;
               height   = 8'd1;
               bpp      = 4'd8;
               idle_pct = 61;
            end
            default: begin
               case ($urandom_range(0, 2))
                  0:       idle_pct = 0;
                  1:       idle_pct = 61;
                  default: idle_pct = 24;
               endcase
            end
         endcase
         apply_config(base, offset, width, height, bpp);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_code(pick_code());
         drain();
      end

      if (mismatches == 0 && pending == 0)
         $display("char_code_to_glyph_address_test: done, clean");
      else
         $display("char_code_to_glyph_address_test: done, errors");
      $finish;
   end

endmodule
